// ----- src/assert_macros.svh -----
// Assertion macros shared by the checker files of this block.
// Each macro expands to one labeled concurrent assertion with an async reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

// ----- src/as24_pkg.sv -----
// Shared constants and types for the angle snap block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package as24_pkg;

	localparam int CORDIC_STEPS  = 32;
	localparam int ANGLE_W       = 32;
	localparam int RES_W         = ANGLE_W + 1;
	localparam int PRESCALE_BITS = 10;
	localparam int GROWTH_BITS   = 3;
	localparam int GAIN_W        = 17;
	localparam int GAIN_SHIFT    = 28;
	localparam int DIR_IDX_W     = 5;

	localparam logic [GAIN_W-1:0] GAIN_INV = 17'd96667;

	// Binary angles of atan(2^-i), 2^32 units per full turn.
	localparam logic [ANGLE_W-1:0] ATAN_UNITS [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5,
		32'd3,         32'd1,         32'd1,         32'd0
	};

	typedef struct packed {
		logic valid;
		logic zero;
	} ctl_t;

endpackage

// ----- src/as24_vec_cell.sv -----
// One vectoring CORDIC micro-rotation, registered.
// Depends on as24_pkg for the arctangent table and the control struct.
`timescale 1ns / 1ps

module as24_vec_cell #(
	parameter int WIDTH  = 38,
	parameter int SIDE_W = 53,
	parameter int SHIFT  = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  as24_pkg::ctl_t               ctl_i,
	input  logic [SIDE_W-1:0]            side_i,
	input  logic signed [WIDTH-1:0]      x_i,
	input  logic signed [WIDTH-1:0]      y_i,
	input  logic [as24_pkg::ANGLE_W-1:0] z_i,
	output as24_pkg::ctl_t               ctl_o,
	output logic [SIDE_W-1:0]            side_o,
	output logic signed [WIDTH-1:0]      x_o,
	output logic signed [WIDTH-1:0]      y_o,
	output logic [as24_pkg::ANGLE_W-1:0] z_o
);
	import as24_pkg::*;

	ctl_t                    ctl_q;
	logic [SIDE_W-1:0]       side_q;
	logic signed [WIDTH-1:0] x_q, y_q, x_sh, y_sh;
	logic [ANGLE_W-1:0]      z_q;

	assign x_sh = x_i >>> SHIFT;
	assign y_sh = y_i >>> SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_i;
		end
	end

	// Drive y toward zero; z collects the angle turned through.
	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_i;
			if (!y_i[WIDTH-1]) begin
				x_q <= x_i + y_sh;
				y_q <= y_i - x_sh;
				z_q <= z_i + ATAN_UNITS[SHIFT];
			end else begin
				x_q <= x_i - y_sh;
				y_q <= y_i + x_sh;
				z_q <= z_i - ATAN_UNITS[SHIFT];
			end
		end
	end

	assign ctl_o  = ctl_q;
	assign side_o = side_q;
	assign x_o    = x_q;
	assign y_o    = y_q;
	assign z_o    = z_q;

endmodule

// ----- src/as24_rot_cell.sv -----
// One rotating CORDIC micro-rotation, registered.
// Depends on as24_pkg for the arctangent table and the control struct.
`timescale 1ns / 1ps

module as24_rot_cell #(
	parameter int WIDTH  = 38,
	parameter int SIDE_W = 53,
	parameter int SHIFT  = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  as24_pkg::ctl_t                    ctl_i,
	input  logic [SIDE_W-1:0]                 side_i,
	input  logic signed [WIDTH-1:0]           x_i,
	input  logic signed [WIDTH-1:0]           y_i,
	input  logic signed [as24_pkg::RES_W-1:0] t_i,
	output as24_pkg::ctl_t                    ctl_o,
	output logic [SIDE_W-1:0]                 side_o,
	output logic signed [WIDTH-1:0]           x_o,
	output logic signed [WIDTH-1:0]           y_o,
	output logic signed [as24_pkg::RES_W-1:0] t_o
);
	import as24_pkg::*;

	ctl_t                    ctl_q;
	logic [SIDE_W-1:0]       side_q;
	logic signed [WIDTH-1:0] x_q, y_q, x_sh, y_sh;
	logic signed [RES_W-1:0] t_q, step;

	assign x_sh = x_i >>> SHIFT;
	assign y_sh = y_i >>> SHIFT;
	assign step = $signed({1'b0, ATAN_UNITS[SHIFT]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_i;
		end
	end

	// Turn toward the residual angle t until it is used up.
	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_i;
			if (!t_i[RES_W-1]) begin
				x_q <= x_i - y_sh;
				y_q <= y_i + x_sh;
				t_q <= t_i - step;
			end else begin
				x_q <= x_i + y_sh;
				y_q <= y_i - x_sh;
				t_q <= t_i + step;
			end
		end
	end

	assign ctl_o  = ctl_q;
	assign side_o = side_q;
	assign x_o    = x_q;
	assign y_o    = y_q;
	assign t_o    = t_q;

endmodule

// ----- src/as24_gain.sv -----
// Gain removal, offset by the start point and saturation, three stages.
// Depends on as24_pkg for the gain constant and the control struct.
`timescale 1ns / 1ps

module as24_gain #(
	parameter int WIDTH      = 38,
	parameter int COORD_BITS = 24,
	parameter int IDX_W      = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  as24_pkg::ctl_t               ctl_i,
	input  logic [2*COORD_BITS+IDX_W-1:0] side_i,
	input  logic signed [WIDTH-1:0]      x_i,
	input  logic signed [WIDTH-1:0]      y_i,
	output as24_pkg::ctl_t               ctl_o,
	output logic signed [COORD_BITS-1:0] ex_o,
	output logic signed [COORD_BITS-1:0] ey_o,
	output logic [IDX_W-1:0]             k_o
);
	import as24_pkg::*;

	localparam int SIDE_W = 2*COORD_BITS + IDX_W;
	localparam int LOW    = WIDTH / 2;
	localparam int HIW    = WIDTH - LOW;
	localparam int PLW    = LOW + GAIN_W;
	localparam int PHW    = HIW + GAIN_W + 1;
	localparam int SW     = WIDTH + GAIN_W + 1;
	localparam int VW     = SW - GAIN_SHIFT;
	localparam int EW     = VW + 1;

	localparam logic signed [SW-1:0] ROUND_C = SW'(64'sd1 <<< (GAIN_SHIFT - 1));
	localparam logic signed [EW-1:0] E_MAX   = EW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
	localparam logic signed [EW-1:0] E_MIN   = EW'(-(64'sd1 <<< (COORD_BITS - 1)));

	ctl_t                         ctl_s1, ctl_s2, ctl_s3;
	logic [SIDE_W-1:0]            side_s1, side_s2;
	logic [PLW-1:0]               plo_x_s1, plo_y_s1;
	logic signed [PHW-1:0]        phi_x_s1, phi_y_s1;
	logic signed [VW-1:0]         vx_s2, vy_s2;
	logic signed [COORD_BITS-1:0] ex_s3, ey_s3;
	logic [IDX_W-1:0]             k_s3;

	logic signed [SW-1:0]         sum_x, sum_y;
	logic signed [COORD_BITS-1:0] sx, sy;
	logic signed [EW-1:0]         ex_sum, ey_sum;
	logic signed [COORD_BITS-1:0] ex_sat, ey_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	// Stage 1: the gain product split into a signed high and unsigned low part.
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1  <= side_i;
			plo_x_s1 <= PLW'(x_i[LOW-1:0]) * PLW'(GAIN_INV);
			plo_y_s1 <= PLW'(y_i[LOW-1:0]) * PLW'(GAIN_INV);
			phi_x_s1 <= PHW'($signed(x_i[WIDTH-1:LOW])) * PHW'($signed({1'b0, GAIN_INV}));
			phi_y_s1 <= PHW'($signed(y_i[WIDTH-1:LOW])) * PHW'($signed({1'b0, GAIN_INV}));
		end
	end

	// Stage 2: recombine, round, floor shift.
	assign sum_x = (SW'(phi_x_s1) <<< LOW) + SW'($signed({1'b0, plo_x_s1})) + ROUND_C;
	assign sum_y = (SW'(phi_y_s1) <<< LOW) + SW'($signed({1'b0, plo_y_s1})) + ROUND_C;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_s1;
			vx_s2   <= sum_x[SW-1:GAIN_SHIFT];
			vy_s2   <= sum_y[SW-1:GAIN_SHIFT];
		end
	end

	// Stage 3: add the start point and clamp to the coordinate range.
	assign sx     = side_s2[SIDE_W-1:COORD_BITS+IDX_W];
	assign sy     = side_s2[COORD_BITS+IDX_W-1:IDX_W];
	assign ex_sum = EW'(sx) + EW'(vx_s2);
	assign ey_sum = EW'(sy) + EW'(vy_s2);

	always_comb begin
		ex_sat = ex_sum[COORD_BITS-1:0];
		ey_sat = ey_sum[COORD_BITS-1:0];
		if (ex_sum > E_MAX) begin
			ex_sat = E_MAX[COORD_BITS-1:0];
		end else if (ex_sum < E_MIN) begin
			ex_sat = E_MIN[COORD_BITS-1:0];
		end
		if (ey_sum > E_MAX) begin
			ey_sat = E_MAX[COORD_BITS-1:0];
		end else if (ey_sum < E_MIN) begin
			ey_sat = E_MIN[COORD_BITS-1:0];
		end
	end

	// A zero-length vector returns the start point in direction zero.
	always_ff @(posedge clk) begin
		if (en) begin
			if (ctl_s2.zero) begin
				ex_s3 <= sx;
				ey_s3 <= sy;
				k_s3  <= '0;
			end else begin
				ex_s3 <= ex_sat;
				ey_s3 <= ey_sat;
				k_s3  <= side_s2[IDX_W-1:0];
			end
		end
	end

	assign ctl_o = ctl_s3;
	assign ex_o  = ex_s3;
	assign ey_o  = ey_s3;
	assign k_o   = k_s3;

endmodule

// ----- src/angle_snap_to_24_directions.sv -----
// Pipeline: input register, difference stage, two 32-cell CORDIC chains with the
// index and table stages between them, three gain stages and the output
// register; the input register loads on the accepting edge itself.
// Throughput: one transaction per cycle; the pipeline stalls only while the
// output skid register holds a second result.
// Reset: arst_n clears all valid bits and the skid flag; data paths are not reset.
`timescale 1ns / 1ps

module angle_snap_to_24_directions #(
	parameter int DIRECTION_COUNT = 24,
	parameter int COORD_BITS      = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  logic signed [COORD_BITS-1:0]   start_x,
	input  logic signed [COORD_BITS-1:0]   start_y,
	input  logic signed [COORD_BITS-1:0]   point_x,
	input  logic signed [COORD_BITS-1:0]   point_y,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output logic signed [COORD_BITS-1:0]   end_x,
	output logic signed [COORD_BITS-1:0]   end_y,
	output logic [as24_pkg::DIR_IDX_W-1:0] direction_index
);
	import as24_pkg::*;

	localparam int WW     = COORD_BITS + 1 + PRESCALE_BITS + GROWTH_BITS;
	localparam int IW     = $clog2(DIRECTION_COUNT);
	localparam int KW     = $clog2(DIRECTION_COUNT + 1);
	localparam int PW     = ANGLE_W + KW;
	localparam int SIDE_W = 2*COORD_BITS + IW;

	localparam logic [PW-1:0]        HALF_TURN_P = PW'(64'd1 << (ANGLE_W - 1));
	localparam logic signed [RES_W-1:0] QUARTER  = RES_W'(64'sd1 <<< (ANGLE_W - 2));
	localparam logic signed [RES_W-1:0] HALF     = RES_W'(64'sd1 <<< (ANGLE_W - 1));

	logic en;

	// Input register.
	logic                         valid_s1;
	logic signed [COORD_BITS-1:0] sx_s1, sy_s1, px_s1, py_s1;

	// Difference, prescale and left-half-plane fold.
	ctl_t                         ctl_s2;
	logic [SIDE_W-1:0]            side_s2;
	logic signed [WW-1:0]         x_s2, y_s2;
	logic [ANGLE_W-1:0]           z_s2;
	logic signed [COORD_BITS:0]   dx_pos, dx_neg, dy_pos, dy_neg;
	logic                         fold;

	// Vectoring chain taps.
	ctl_t                 vc_ctl  [CORDIC_STEPS+1];
	logic [SIDE_W-1:0]    vc_side [CORDIC_STEPS+1];
	logic signed [WW-1:0] vc_x    [CORDIC_STEPS+1];
	logic signed [WW-1:0] vc_y    [CORDIC_STEPS+1];
	logic [ANGLE_W-1:0]   vc_z    [CORDIC_STEPS+1];

	// Direction index.
	ctl_t                 ctl_s3;
	logic [SIDE_W-1:0]    side_s3;
	logic signed [WW-1:0] m_s3;
	logic [PW-1:0]        k_prod;
	logic [KW-1:0]        k_raw;
	logic [IW-1:0]        k_next;

	// Target angle lookup and quadrant fold.
	logic [ANGLE_W-1:0]      t_lut [DIRECTION_COUNT];
	ctl_t                    ctl_s4;
	logic [SIDE_W-1:0]       side_s4;
	logic signed [WW-1:0]    x_s4;
	logic signed [RES_W-1:0] t_s4, t_raw, t_fold;
	logic                    flip;

	// Rotating chain taps.
	ctl_t                    rc_ctl  [CORDIC_STEPS+1];
	logic [SIDE_W-1:0]       rc_side [CORDIC_STEPS+1];
	logic signed [WW-1:0]    rc_x    [CORDIC_STEPS+1];
	logic signed [WW-1:0]    rc_y    [CORDIC_STEPS+1];
	logic signed [RES_W-1:0] rc_t    [CORDIC_STEPS+1];

	// Gain stage result and output with skid.
	ctl_t                         fin_ctl;
	logic signed [COORD_BITS-1:0] fin_x, fin_y;
	logic [IW-1:0]                fin_k;
	logic                         out_valid_q, skid_q;
	logic signed [COORD_BITS-1:0] out_x_q, out_y_q, skid_x_q, skid_y_q;
	logic [IW-1:0]                out_k_q, skid_k_q;
	logic                         fin_take, load_out_fin, load_skid, load_out_skid;
	logic [IW+DIR_IDX_W-1:0]      k_wide;

	// The whole pipeline moves unless the skid register is occupied.
	assign en        = !skid_q;
	assign req_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1 <= start_x;
			sy_s1 <= start_y;
			px_s1 <= point_x;
			py_s1 <= point_y;
		end
	end

	// Both signs of the difference are formed side by side to avoid a negate.
	assign dx_pos = (COORD_BITS+1)'(px_s1) - (COORD_BITS+1)'(sx_s1);
	assign dx_neg = (COORD_BITS+1)'(sx_s1) - (COORD_BITS+1)'(px_s1);
	assign dy_pos = (COORD_BITS+1)'(py_s1) - (COORD_BITS+1)'(sy_s1);
	assign dy_neg = (COORD_BITS+1)'(sy_s1) - (COORD_BITS+1)'(py_s1);
	assign fold   = dx_pos[COORD_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2.valid <= valid_s1;
			ctl_s2.zero  <= (px_s1 == sx_s1) && (py_s1 == sy_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= {sx_s1, sy_s1, IW'(0)};
			x_s2    <= WW'(fold ? dx_neg : dx_pos) <<< PRESCALE_BITS;
			y_s2    <= WW'(fold ? dy_neg : dy_pos) <<< PRESCALE_BITS;
			z_s2    <= fold ? ANGLE_W'(64'd1 << (ANGLE_W - 1)) : '0;
		end
	end

	assign vc_ctl[0]  = ctl_s2;
	assign vc_side[0] = side_s2;
	assign vc_x[0]    = x_s2;
	assign vc_y[0]    = y_s2;
	assign vc_z[0]    = z_s2;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
		as24_vec_cell #(
			.WIDTH (WW),
			.SIDE_W(SIDE_W),
			.SHIFT (i)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.ctl_i (vc_ctl[i]),
			.side_i(vc_side[i]),
			.x_i   (vc_x[i]),
			.y_i   (vc_y[i]),
			.z_i   (vc_z[i]),
			.ctl_o (vc_ctl[i+1]),
			.side_o(vc_side[i+1]),
			.x_o   (vc_x[i+1]),
			.y_o   (vc_y[i+1]),
			.z_o   (vc_z[i+1])
		);
	end

	// Nearest direction, ties upward; a full turn wraps to direction zero.
	assign k_prod = PW'(vc_z[CORDIC_STEPS]) * PW'(DIRECTION_COUNT) + HALF_TURN_P;
	assign k_raw  = k_prod[PW-1:ANGLE_W];
	assign k_next = (k_raw >= KW'(DIRECTION_COUNT)) ? '0 : IW'(k_raw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s3 <= vc_ctl[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= {vc_side[CORDIC_STEPS][SIDE_W-1:IW], k_next};
			m_s3    <= vc_x[CORDIC_STEPS];
		end
	end

	// Target angle of each direction, rounded to the nearest binary unit.
	for (genvar g = 0; g < DIRECTION_COUNT; g++) begin : g_lut
		localparam logic [63:0] TV =
			((64'(g) << ANGLE_W) + 64'(DIRECTION_COUNT / 2)) / 64'(DIRECTION_COUNT);
		assign t_lut[g] = TV[ANGLE_W-1:0];
	end

	// Angles beyond a quarter turn start from the negated vector instead.
	assign t_raw = RES_W'($signed(t_lut[side_s3[IW-1:0]]));

	always_comb begin
		t_fold = t_raw;
		flip   = 1'b0;
		if (t_raw > QUARTER) begin
			t_fold = t_raw - HALF;
			flip   = 1'b1;
		end else if (t_raw < -QUARTER) begin
			t_fold = t_raw + HALF;
			flip   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_s3;
			x_s4    <= flip ? -m_s3 : m_s3;
			t_s4    <= t_fold;
		end
	end

	assign rc_ctl[0]  = ctl_s4;
	assign rc_side[0] = side_s4;
	assign rc_x[0]    = x_s4;
	assign rc_y[0]    = '0;
	assign rc_t[0]    = t_s4;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		as24_rot_cell #(
			.WIDTH (WW),
			.SIDE_W(SIDE_W),
			.SHIFT (i)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.ctl_i (rc_ctl[i]),
			.side_i(rc_side[i]),
			.x_i   (rc_x[i]),
			.y_i   (rc_y[i]),
			.t_i   (rc_t[i]),
			.ctl_o (rc_ctl[i+1]),
			.side_o(rc_side[i+1]),
			.x_o   (rc_x[i+1]),
			.y_o   (rc_y[i+1]),
			.t_o   (rc_t[i+1])
		);
	end

	as24_gain #(
		.WIDTH     (WW),
		.COORD_BITS(COORD_BITS),
		.IDX_W     (IW)
	) u_gain (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.ctl_i (rc_ctl[CORDIC_STEPS]),
		.side_i(rc_side[CORDIC_STEPS]),
		.x_i   (rc_x[CORDIC_STEPS]),
		.y_i   (rc_y[CORDIC_STEPS]),
		.ctl_o (fin_ctl),
		.ex_o  (fin_x),
		.ey_o  (fin_y),
		.k_o   (fin_k)
	);

	// A result leaving the pipeline goes to the output register when that is
	// free or being drained, and to the skid register otherwise.
	assign fin_take      = en && fin_ctl.valid;
	assign load_out_fin  = fin_take && (!out_valid_q || rsp_ready);
	assign load_skid     = fin_take && out_valid_q && !rsp_ready;
	assign load_out_skid = skid_q && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_q      <= 1'b0;
		end else begin
			out_valid_q <= load_out_fin || load_out_skid || (out_valid_q && !rsp_ready);
			skid_q      <= load_skid || (skid_q && !rsp_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (load_out_skid) begin
			out_x_q <= skid_x_q;
			out_y_q <= skid_y_q;
			out_k_q <= skid_k_q;
		end else if (load_out_fin) begin
			out_x_q <= fin_x;
			out_y_q <= fin_y;
			out_k_q <= fin_k;
		end
		if (load_skid) begin
			skid_x_q <= fin_x;
			skid_y_q <= fin_y;
			skid_k_q <= fin_k;
		end
	end

	assign k_wide          = (IW+DIR_IDX_W)'(out_k_q);
	assign rsp_valid       = out_valid_q;
	assign end_x           = out_x_q;
	assign end_y           = out_y_q;
	assign direction_index = k_wide[DIR_IDX_W-1:0];

endmodule

// ----- src/as24_checker.sv -----
// Port-level checks for the angle snap block, bound to its top level.
// Depends on as24_pkg for field widths and on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module as24_checker #(
	parameter int DIRECTION_COUNT = 24,
	parameter int COORD_BITS      = 24
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic signed [COORD_BITS-1:0]   end_x,
	input logic signed [COORD_BITS-1:0]   end_y,
	input logic [as24_pkg::DIR_IDX_W-1:0] direction_index
);
	import as24_pkg::*;

	// The reported direction never reaches the direction count.
	`ASSERT_IMPLIES(a_index_range, clk, arst_n, rsp_valid, 32'(direction_index) < DIRECTION_COUNT)

	// Back-pressure at the input only appears with two results waiting.
	`ASSERT_IMPLIES(a_stall_needs_result, clk, arst_n, !req_ready, rsp_valid)

	// A drained output always frees the input side in the next cycle.
	`ASSERT_NEXT(a_stall_clears, clk, arst_n, !req_ready && rsp_valid && rsp_ready, req_ready)

	// A result waiting for the consumer is held unchanged.
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(end_x) && $stable(end_y) && $stable(direction_index))

endmodule

bind angle_snap_to_24_directions as24_checker #(
	.DIRECTION_COUNT(DIRECTION_COUNT),
	.COORD_BITS     (COORD_BITS)
) u_as24_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_ready      (req_ready),
	.rsp_valid      (rsp_valid),
	.rsp_ready      (rsp_ready),
	.end_x          (end_x),
	.end_y          (end_y),
	.direction_index(direction_index)
);
